// ----- sv/pev_pkg.sv -----
// ---------------------------------------------------------------------------
// pev_pkg: shared types and constants for the particle Euler update block
// Beat layouts of both channels, register indexes and pipeline control.
// ---------------------------------------------------------------------------
package pev_pkg;

    localparam int NUM_STAGES = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP = 3'd0,
        CFG_GRAV_X    = 3'd1,
        CFG_GRAV_Y    = 3'd2,
        CFG_GRAV_Z    = 3'd3,
        CFG_DAMPING   = 3'd4,
        CFG_END_COLOR = 3'd5,
        CFG_END_SCALE = 3'd6,
        CFG_LERP_MODE = 3'd7
    } t_cfg_idx;

    localparam logic [15:0] TIME_STEP_RST = 16'd1092;
    localparam logic [16:0] DAMPING_RST   = 17'd65536;

    typedef struct packed {
        logic        [17:0] life_in;
        logic        [23:0] inverse_lifetime;
        logic signed [31:0] velocity_x_in;
        logic signed [31:0] velocity_y_in;
        logic signed [31:0] velocity_z_in;
        logic signed [31:0] position_x_in;
        logic signed [31:0] position_y_in;
        logic signed [31:0] position_z_in;
        logic        [31:0] color_in;
        logic        [31:0] scale_in;
        logic               last_in_frame;
    } t_pev_in;

    typedef struct packed {
        logic        [17:0] life_out;
        logic signed [31:0] velocity_x_out;
        logic signed [31:0] velocity_y_out;
        logic signed [31:0] velocity_z_out;
        logic signed [31:0] position_x_out;
        logic signed [31:0] position_y_out;
        logic signed [31:0] position_z_out;
        logic        [31:0] color_out;
        logic        [31:0] scale_out;
        logic               expired;
        logic               last_out;
    } t_pev_out;

    // Per-stage load enables shared by the datapath lanes.
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

endpackage

// ----- sv/particle_euler_update.sv -----
// ---------------------------------------------------------------------------
// particle_euler_update: one-frame Euler step for a stream of particles
// Life, damped velocity, position and optional color and scale blends.
// ---------------------------------------------------------------------------
//   channel   direction   handshake                     beat
//   input     in          i_in_valid / o_in_stall       i_in_data  (t_pev_in)
//   output    out         o_out_valid / i_out_stall     o_out_data (t_pev_out)
//   config    in          i_cfg_wr_en                   i_cfg_addr, i_cfg_wdata
//
// One beat enters per cycle while o_in_stall is low; each beat then passes through
// the five-stage multiply chain in order (gravity add, damping multiply,
// saturate, dt multiply, position add). Each stage moves when it is empty or
// the stage after it moves, so a stall at the output backs up stage by stage
// and bubbles are squeezed out. Reset clears the valid bits and loads the
// configuration registers with their reset values; the data stages are not reset.
module particle_euler_update (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  pev_pkg::t_pev_in                    i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output pev_pkg::t_pev_out                   o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_wr_en,
    input  logic [pev_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [pev_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int NS = pev_pkg::NUM_STAGES;

    // Configuration registers.
    logic        [15:0] r_tstep;
    logic signed [31:0] r_grav_x, r_grav_y, r_grav_z;
    logic        [16:0] r_damp;
    logic        [31:0] r_end_color, r_end_scale;
    logic        [1:0]  r_lerp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tstep     <= pev_pkg::TIME_STEP_RST;
            r_grav_x    <= '0;
            r_grav_y    <= '0;
            r_grav_z    <= '0;
            r_damp      <= pev_pkg::DAMPING_RST;
            r_end_color <= '0;
            r_end_scale <= '0;
            r_lerp      <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (pev_pkg::t_cfg_idx'(i_cfg_addr))
                pev_pkg::CFG_TIME_STEP: r_tstep     <= i_cfg_wdata[15:0];
                pev_pkg::CFG_GRAV_X:    r_grav_x    <= $signed(i_cfg_wdata);
                pev_pkg::CFG_GRAV_Y:    r_grav_y    <= $signed(i_cfg_wdata);
                pev_pkg::CFG_GRAV_Z:    r_grav_z    <= $signed(i_cfg_wdata);
                pev_pkg::CFG_DAMPING:   r_damp      <= i_cfg_wdata[16:0];
                pev_pkg::CFG_END_COLOR: r_end_color <= i_cfg_wdata;
                pev_pkg::CFG_END_SCALE: r_end_scale <= i_cfg_wdata;
                pev_pkg::CFG_LERP_MODE: r_lerp      <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control.
    logic [NS-1:0]      r_vld, n_vld;
    pev_pkg::t_pipe_ctl w_ctl;

    always_comb begin
        w_ctl.en[NS-1] = !r_vld[NS-1] || !i_out_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_ctl.en[k] = !r_vld[k] || w_ctl.en[k+1];
        end
        n_vld = r_vld;
        if (w_ctl.en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_ctl.en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_stall = !w_ctl.en[0];

    // Life path and carried fields.
    logic [39:0] r_lprod_s1, n_lprod_s1;
    logic [17:0] r_life_s1;
    logic [17:0] r_life_s2, n_life_s2;
    logic [17:0] r_life_s3, r_life_s4, r_life_s5;
    logic [24:0] w_lsum;
    logic [31:0] r_color_s1, r_color_s2, r_color_s3, r_color_s4;
    logic [31:0] r_scale_s1, r_scale_s2, r_scale_s3, r_scale_s4;
    logic [31:0] r_color_s5, n_color_s5, r_scale_s5, n_scale_s5;
    logic [NS-1:0] r_last;

    logic [15:0] w_blend_c [4];
    logic [15:0] w_blend_s [2];

    always_comb begin
        n_lprod_s1 = 40'(r_tstep) * 40'(i_in_data.inverse_lifetime);
        w_lsum     = 25'(r_life_s1) + 25'(r_lprod_s1[39:16]);
        n_life_s2  = (w_lsum[24:18] != '0) ? '1 : w_lsum[17:0];

        if (r_lerp[0]) begin
            n_color_s5 = {w_blend_c[3][7:0], w_blend_c[2][7:0],
                          w_blend_c[1][7:0], w_blend_c[0][7:0]};
        end else begin
            n_color_s5 = r_color_s4;
        end
        if (r_lerp[1]) begin
            n_scale_s5 = {w_blend_s[1], w_blend_s[0]};
        end else begin
            n_scale_s5 = r_scale_s4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[0]) begin
            r_lprod_s1 <= n_lprod_s1;
            r_life_s1  <= i_in_data.life_in;
            r_color_s1 <= i_in_data.color_in;
            r_scale_s1 <= i_in_data.scale_in;
            r_last[0]  <= i_in_data.last_in_frame;
        end
        if (w_ctl.en[1]) begin
            r_life_s2  <= n_life_s2;
            r_color_s2 <= r_color_s1;
            r_scale_s2 <= r_scale_s1;
            r_last[1]  <= r_last[0];
        end
        if (w_ctl.en[2]) begin
            r_life_s3  <= r_life_s2;
            r_color_s3 <= r_color_s2;
            r_scale_s3 <= r_scale_s2;
            r_last[2]  <= r_last[1];
        end
        if (w_ctl.en[3]) begin
            r_life_s4  <= r_life_s3;
            r_color_s4 <= r_color_s3;
            r_scale_s4 <= r_scale_s3;
            r_last[3]  <= r_last[2];
        end
        if (w_ctl.en[4]) begin
            r_life_s5  <= r_life_s4;
            r_color_s5 <= n_color_s5;
            r_scale_s5 <= n_scale_s5;
            r_last[4]  <= r_last[3];
        end
    end

    // Blend lanes take the spawn values and the new life at stage two.
    for (genvar c = 0; c < 4; c++) begin : g_color
        pev_blend_lane u_blend (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_narrow(1'b1),
            .i_start ({8'd0, r_color_s2[8*c +: 8]}),
            .i_end   ({8'd0, r_end_color[8*c +: 8]}),
            .i_t     (r_life_s2),
            .o_value (w_blend_c[c])
        );
    end

    for (genvar s = 0; s < 2; s++) begin : g_scale
        pev_blend_lane u_blend (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_narrow(1'b0),
            .i_start (r_scale_s2[16*s +: 16]),
            .i_end   (r_end_scale[16*s +: 16]),
            .i_t     (r_life_s2),
            .o_value (w_blend_s[s])
        );
    end

    logic signed [31:0] w_vel_x, w_vel_y, w_vel_z;
    logic signed [31:0] w_pos_x, w_pos_y, w_pos_z;

    pev_kin_lane u_kin_x (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_vel  (i_in_data.velocity_x_in),
        .i_pos  (i_in_data.position_x_in),
        .i_grav (r_grav_x),
        .i_damp (r_damp),
        .i_tstep(r_tstep),
        .o_vel  (w_vel_x),
        .o_pos  (w_pos_x)
    );

    pev_kin_lane u_kin_y (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_vel  (i_in_data.velocity_y_in),
        .i_pos  (i_in_data.position_y_in),
        .i_grav (r_grav_y),
        .i_damp (r_damp),
        .i_tstep(r_tstep),
        .o_vel  (w_vel_y),
        .o_pos  (w_pos_y)
    );

    pev_kin_lane u_kin_z (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_vel  (i_in_data.velocity_z_in),
        .i_pos  (i_in_data.position_z_in),
        .i_grav (r_grav_z),
        .i_damp (r_damp),
        .i_tstep(r_tstep),
        .o_vel  (w_vel_z),
        .o_pos  (w_pos_z)
    );

    always_comb begin
        o_out_data.life_out       = r_life_s5;
        o_out_data.velocity_x_out = w_vel_x;
        o_out_data.velocity_y_out = w_vel_y;
        o_out_data.velocity_z_out = w_vel_z;
        o_out_data.position_x_out = w_pos_x;
        o_out_data.position_y_out = w_pos_y;
        o_out_data.position_z_out = w_pos_z;
        o_out_data.color_out      = r_color_s5;
        o_out_data.scale_out      = r_scale_s5;
        // Life at or above 1.0 in Q2.16 has one of its two integer bits set.
        o_out_data.expired        = (r_life_s5[17:16] != 2'b00);
        o_out_data.last_out       = r_last[NS-1];
    end

    assign o_out_valid = r_vld[NS-1];

endmodule

// ----- sv/pev_kin_lane.sv -----
// ---------------------------------------------------------------------------
// pev_kin_lane: one axis of the velocity and position update
// Adds gravity, applies damping, then advances position by v * dt, over
// five register stages with saturation to signed Q16.16.
// ---------------------------------------------------------------------------
module pev_kin_lane (
    input  logic               i_clk,
    input  pev_pkg::t_pipe_ctl i_ctl,
    input  logic signed [31:0] i_vel,
    input  logic signed [31:0] i_pos,
    input  logic signed [31:0] i_grav,
    input  logic        [16:0] i_damp,
    input  logic        [15:0] i_tstep,
    output logic signed [31:0] o_vel,
    output logic signed [31:0] o_pos
);

    localparam logic signed [34:0] VMAX35 = 35'sd2147483647;
    localparam logic signed [34:0] VMIN35 = -35'sd2147483648;
    localparam logic signed [33:0] VMAX34 = 34'sd2147483647;
    localparam logic signed [33:0] VMIN34 = -34'sd2147483648;

    logic signed [32:0] r_vsum_s1, n_vsum_s1;
    logic signed [31:0] r_pos_s1, r_pos_s2, r_pos_s3, r_pos_s4, r_pos_s5;
    logic signed [50:0] r_vprod_s2, n_vprod_s2;
    logic signed [31:0] r_vel_s3, n_vel_s3;
    logic signed [31:0] r_vel_s4, r_vel_s5;
    logic signed [48:0] r_pprod_s4, n_pprod_s4;
    logic signed [31:0] n_pos_s5;

    logic signed [34:0] w_vshift;
    logic signed [32:0] w_pshift;
    logic signed [33:0] w_psum;

    always_comb begin
        n_vsum_s1  = 33'(i_vel) + 33'(i_grav);
        n_vprod_s2 = 51'(r_vsum_s1) * 51'($signed({1'b0, i_damp}));

        // Arithmetic shift right gives the floor of the Q16 product.
        w_vshift = 35'(r_vprod_s2 >>> 16);
        if (w_vshift > VMAX35) begin
            n_vel_s3 = 32'sh7fffffff;
        end else if (w_vshift < VMIN35) begin
            n_vel_s3 = -32'sh80000000;
        end else begin
            n_vel_s3 = 32'(w_vshift);
        end

        n_pprod_s4 = 49'(r_vel_s3) * 49'($signed({1'b0, i_tstep}));

        w_pshift = 33'(r_pprod_s4 >>> 16);
        w_psum   = 34'(r_pos_s4) + 34'(w_pshift);
        if (w_psum > VMAX34) begin
            n_pos_s5 = 32'sh7fffffff;
        end else if (w_psum < VMIN34) begin
            n_pos_s5 = -32'sh80000000;
        end else begin
            n_pos_s5 = 32'(w_psum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_vsum_s1 <= n_vsum_s1;
            r_pos_s1  <= i_pos;
        end
        if (i_ctl.en[1]) begin
            r_vprod_s2 <= n_vprod_s2;
            r_pos_s2   <= r_pos_s1;
        end
        if (i_ctl.en[2]) begin
            r_vel_s3 <= n_vel_s3;
            r_pos_s3 <= r_pos_s2;
        end
        if (i_ctl.en[3]) begin
            r_pprod_s4 <= n_pprod_s4;
            r_vel_s4   <= r_vel_s3;
            r_pos_s4   <= r_pos_s3;
        end
        if (i_ctl.en[4]) begin
            r_vel_s5 <= r_vel_s4;
            r_pos_s5 <= n_pos_s5;
        end
    end

    assign o_vel = r_vel_s5;
    assign o_pos = r_pos_s5;

endmodule

// ----- sv/pev_blend_lane.sv -----
// ---------------------------------------------------------------------------
// pev_blend_lane: one channel of the color or scale blend
// Moves a channel from its spawn value toward the end value by life, with
// round-half-up and clamping to the channel range, over two stages.
// ---------------------------------------------------------------------------
module pev_blend_lane (
    input  logic               i_clk,
    input  pev_pkg::t_pipe_ctl i_ctl,
    input  logic               i_narrow,
    input  logic        [15:0] i_start,
    input  logic        [15:0] i_end,
    input  logic        [17:0] i_t,
    output logic        [15:0] o_value
);

    logic signed [35:0] r_prod, n_prod;
    logic        [15:0] r_start;
    logic        [15:0] r_value, n_value;

    logic signed [16:0] w_diff;
    logic signed [36:0] w_acc;
    logic signed [20:0] w_q;
    logic signed [20:0] w_max;

    always_comb begin
        w_diff = $signed({1'b0, i_end}) - $signed({1'b0, i_start});
        n_prod = 36'(w_diff) * 36'($signed({1'b0, i_t}));

        w_acc = $signed({5'd0, r_start, 16'd0}) + 37'(r_prod) + 37'sd32768;
        w_q   = 21'(w_acc >>> 16);
        // Color channels are 8 bits wide, scale channels 16.
        w_max = i_narrow ? 21'sd255 : 21'sd65535;
        if (w_q < 21'sd0) begin
            n_value = 16'd0;
        end else if (w_q > w_max) begin
            n_value = 16'(w_max);
        end else begin
            n_value = 16'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_prod  <= n_prod;
            r_start <= i_start;
        end
        if (i_ctl.en[3]) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// ----- sim/particle_euler_update_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// particle_euler_update_tb: self-checking bench for the particle Euler update
// Particles are streamed through the block under several register settings
// and idle patterns. A bit-accurate predictor computes each particle's next
// frame when its beat is taken, and every output beat is compared field by
// field with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module particle_euler_update_tb;

    localparam longint LIFE_MAX = 262143;
    localparam longint ONE_Q16  = 65536;

    typedef struct packed {
        logic        [15:0] time_step;
        logic signed [31:0] grav_x;
        logic signed [31:0] grav_y;
        logic signed [31:0] grav_z;
        logic        [16:0] damping;
        logic        [31:0] end_color;
        logic        [31:0] end_scale;
        logic        [1:0]  lerp;
    } t_frame_cfg;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    pev_pkg::t_pev_in  in_data   = '0;
    logic              in_stall;
    logic              out_valid;
    pev_pkg::t_pev_out out_data;
    logic              out_stall = 1'b0;
    logic              cfg_wr_en = 1'b0;
    pev_pkg::t_cfg_idx cfg_addr  = pev_pkg::CFG_TIME_STEP;
    logic [pev_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    t_frame_cfg        cfg_now;
    pev_pkg::t_pev_out pending_particles [$];
    int                mismatch_count = 0;
    int                stall_pct      = 0;
    int                hold_left      = 0;

    always #2 clk = ~clk;

    particle_euler_update i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    // ---------------------------------------------------------------- predictor
    function automatic longint clamp_s32(input longint x);
        if (x < -longint'(32'h8000_0000)) return -longint'(32'h8000_0000);
        if (x > longint'(32'h7FFF_FFFF)) return longint'(32'h7FFF_FFFF);
        return x;
    endfunction

    // Blend one channel from spawn toward end by t (Q2.16), halves rounded up.
    function automatic longint blend_channel(input longint s, input longint e,
                                             input longint t, input longint maxv);
        longint acc;
        acc = s * ONE_Q16 + (e - s) * t;
        acc = (acc + 32768) >>> 16;
        if (acc < 0) return 0;
        if (acc > maxv) return maxv;
        return acc;
    endfunction

    function automatic pev_pkg::t_pev_out advance_particle(input pev_pkg::t_pev_in p,
                                                           input t_frame_cfg c);
        pev_pkg::t_pev_out r;
        longint      life;
        longint      vel;
        longint      pos;
        longint      v_in [3];
        longint      p_in [3];
        longint      g    [3];
        logic [31:0] v_out [3];
        logic [31:0] p_out [3];
        life = longint'(p.life_in) +
               ((longint'(c.time_step) * longint'(p.inverse_lifetime)) >>> 16);
        if (life > LIFE_MAX) life = LIFE_MAX;
        v_in[0] = longint'(p.velocity_x_in);
        v_in[1] = longint'(p.velocity_y_in);
        v_in[2] = longint'(p.velocity_z_in);
        p_in[0] = longint'(p.position_x_in);
        p_in[1] = longint'(p.position_y_in);
        p_in[2] = longint'(p.position_z_in);
        g[0]    = longint'(c.grav_x);
        g[1]    = longint'(c.grav_y);
        g[2]    = longint'(c.grav_z);
        for (int k = 0; k < 3; k++) begin
            // The gravity sum stays at full width; only the damped value saturates.
            vel = clamp_s32(((v_in[k] + g[k]) * longint'(c.damping)) >>> 16);
            pos = clamp_s32(p_in[k] + ((vel * longint'(c.time_step)) >>> 16));
            v_out[k] = vel[31:0];
            p_out[k] = pos[31:0];
        end
        r.life_out       = life[17:0];
        r.velocity_x_out = v_out[0];
        r.velocity_y_out = v_out[1];
        r.velocity_z_out = v_out[2];
        r.position_x_out = p_out[0];
        r.position_y_out = p_out[1];
        r.position_z_out = p_out[2];
        r.color_out      = p.color_in;
        r.scale_out      = p.scale_in;
        if (c.lerp[0]) begin
            for (int k = 0; k < 4; k++)
                r.color_out[8*k +: 8] = 8'(blend_channel(longint'(p.color_in[8*k +: 8]),
                                                         longint'(c.end_color[8*k +: 8]),
                                                         life, 255));
        end
        if (c.lerp[1]) begin
            for (int k = 0; k < 2; k++)
                r.scale_out[16*k +: 16] = 16'(blend_channel(longint'(p.scale_in[16*k +: 16]),
                                                            longint'(c.end_scale[16*k +: 16]),
                                                            life, 65535));
        end
        r.expired  = (life >= ONE_Q16);
        r.last_out = p.last_in_frame;
        return r;
    endfunction

    // ------------------------------------------------------------ value sources
    function automatic pev_pkg::t_pev_in make_particle(input logic [17:0] life,
                                              input logic [23:0] inv,
                                              input logic [31:0] vx, input logic [31:0] vy,
                                              input logic [31:0] vz, input logic [31:0] px,
                                              input logic [31:0] py, input logic [31:0] pz,
                                              input logic [31:0] color,
                                              input logic [31:0] scale, input logic last);
        pev_pkg::t_pev_in p;
        p.life_in          = life;
        p.inverse_lifetime = inv;
        p.velocity_x_in    = vx;
        p.velocity_y_in    = vy;
        p.velocity_z_in    = vz;
        p.position_x_in    = px;
        p.position_y_in    = py;
        p.position_z_in    = pz;
        p.color_in         = color;
        p.scale_in         = scale;
        p.last_in_frame    = last;
        return p;
    endfunction

    function automatic t_frame_cfg make_cfg(input logic [15:0] ts, input logic [31:0] gx,
                                            input logic [31:0] gy, input logic [31:0] gz,
                                            input logic [16:0] damp, input logic [31:0] ec,
                                            input logic [31:0] es, input logic [1:0] lerp);
        t_frame_cfg c;
        c.time_step = ts;
        c.grav_x    = gx;
        c.grav_y    = gy;
        c.grav_z    = gz;
        c.damping   = damp;
        c.end_color = ec;
        c.end_scale = es;
        c.lerp      = lerp;
        return c;
    endfunction

    // Signed Q16.16 word: a small magnitude, one of the rails or any random value.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic pev_pkg::t_pev_in random_particle();
        logic [17:0] life;
        logic [23:0] inv;
        case ($urandom_range(0, 9))
            0:       life = 18'($urandom_range(0, 262143));
            1:       life = 18'($urandom_range(65530, 65540));
            default: life = 18'($urandom_range(0, 70000));
        endcase
        case ($urandom_range(0, 5))
            0:       inv = 24'($urandom);
            1:       inv = 24'hFF_FFFF;
            default: inv = 24'($urandom_range(0, 32'h0001_FFFF));
        endcase
        return make_particle(life, inv, pick_word(), pick_word(), pick_word(), pick_word(),
                             pick_word(), pick_word(), $urandom, $urandom,
                             1'($urandom_range(0, 1)));
    endfunction

    function automatic t_frame_cfg random_cfg();
        t_frame_cfg c;
        case ($urandom_range(0, 3))
            0:       c.time_step = 16'hFFFF;
            1:       c.time_step = 16'($urandom_range(0, 4000));
            default: c.time_step = 16'($urandom);
        endcase
        c.grav_x = pick_word();
        c.grav_y = pick_word();
        c.grav_z = pick_word();
        case ($urandom_range(0, 5))
            0:       c.damping = '0;
            1:       c.damping = pev_pkg::DAMPING_RST;
            2:       c.damping = 17'h1_FFFF;
            3:       c.damping = 17'($urandom_range(60000, 65536));
            default: c.damping = 17'($urandom);
        endcase
        c.end_color = $urandom;
        c.end_scale = $urandom;
        c.lerp      = 2'($urandom_range(0, 3));
        return c;
    endfunction

    // ----------------------------------------------------------------- drivers
    task automatic write_reg(input pev_pkg::t_cfg_idx idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // Only called with the pipeline empty, so the new setting applies to
    // every particle sent afterwards.
    task automatic apply_config(input t_frame_cfg c);
        write_reg(pev_pkg::CFG_TIME_STEP, 32'(c.time_step));
        write_reg(pev_pkg::CFG_GRAV_X, c.grav_x);
        write_reg(pev_pkg::CFG_GRAV_Y, c.grav_y);
        write_reg(pev_pkg::CFG_GRAV_Z, c.grav_z);
        write_reg(pev_pkg::CFG_DAMPING, 32'(c.damping));
        write_reg(pev_pkg::CFG_END_COLOR, c.end_color);
        write_reg(pev_pkg::CFG_END_SCALE, c.end_scale);
        write_reg(pev_pkg::CFG_LERP_MODE, 32'(c.lerp));
        cfg_wr_en <= 1'b0;
        cfg_now = c;
    endtask

    // Each cycle before a beat is idle with the given odds; valid stays high
    // after the beat is taken until the next idle cycle.
    task automatic send_particle(input pev_pkg::t_pev_in p, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_particles.push_back(advance_particle(p, cfg_now));
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_particles.size() != 0) @(posedge clk);
        repeat (pev_pkg::NUM_STAGES + 2) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ----------------------------------------------------------------- checker
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin : result_monitor
        pev_pkg::t_pev_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_particles.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected beat: expected none, got %h", $time, out_data);
            end else begin
                want = pending_particles.pop_front();
                check_field("life_out", 32'(want.life_out), 32'(out_data.life_out));
                check_field("velocity_x_out", want.velocity_x_out, out_data.velocity_x_out);
                check_field("velocity_y_out", want.velocity_y_out, out_data.velocity_y_out);
                check_field("velocity_z_out", want.velocity_z_out, out_data.velocity_z_out);
                check_field("position_x_out", want.position_x_out, out_data.position_x_out);
                check_field("position_y_out", want.position_y_out, out_data.position_y_out);
                check_field("position_z_out", want.position_z_out, out_data.position_z_out);
                check_field("color_out", want.color_out, out_data.color_out);
                check_field("scale_out", want.scale_out, out_data.scale_out);
                check_field("expired", 32'(want.expired), 32'(out_data.expired));
                check_field("last_out", 32'(want.last_out), 32'(out_data.last_out));
            end
        end
    end

    // ------------------------------------------------------------------- tests
    task automatic test_reset_values();
        send_particle(make_particle(18'd0, 24'h00_F000, 32'h0001_0000, 32'hFFFF_0000, 32'h0,
                                    32'h0010_0000, 32'h0, 32'h8000_0000, 32'h1122_3344,
                                    32'h0100_0100, 1'b0), 0);
        send_particle(make_particle(18'd65000, 24'h00_EA60, 32'h0000_8000, 32'h0,
                                    32'hFFFF_8000, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
                                    32'h0, 1'b1), 0);
        send_particle('0, 0);
        wait_for_drain();
    endtask

    task automatic test_field_extremes();
        // Largest time step and damping gain, gravity on both rails, both blends on.
        apply_config(make_cfg(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 17'h1_FFFF,
                              32'hFFFF_FFFF, 32'h0, 2'b11));
        send_particle('0, 0);
        send_particle(make_particle(18'h3_FFFF, 24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 0);
        send_particle(make_particle(18'd0, 24'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0), 0);
        send_particle(make_particle(18'd1000, 24'h01_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                    32'h0001_0000, 32'h7FFF_0000, 32'h8000_FFFF,
                                    32'h0000_0001, 32'h8040_2010, 32'h0080_0100, 1'b1), 0);
        wait_for_drain();
        // Zero time step and zero damping, blends off: color and scale pass through.
        apply_config(make_cfg(16'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 17'h0,
                              32'h0, 32'hFFFF_FFFF, 2'b00));
        send_particle(make_particle(18'h3_FFFF, 24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                    32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b0), 0);
        send_particle(make_particle(18'd65536, 24'h00_0001, 32'h0, 32'h0, 32'h0, 32'h0,
                                    32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1), 0);
        wait_for_drain();
    endtask

    task automatic test_lerp_boundaries();
        // With a zero time step the blend factor is exactly the incoming life.
        apply_config(make_cfg(16'h0, 32'h0, 32'h0, 32'h0, pev_pkg::DAMPING_RST, 32'hFF00_FF00,
                              32'hFFFF_0000, 2'b11));
        send_particle(make_particle(18'd0, 24'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                    32'h00FF_8001, 32'h0000_FFFF, 1'b0), 0);
        // Exactly half way: a tie that has to round up.
        send_particle(make_particle(18'd32768, 24'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                    32'h0, 32'h00FF_0001, 32'h0000_FFFF, 1'b0), 0);
        send_particle(make_particle(18'd32767, 24'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                    32'h0, 32'h00FF_0001, 32'h0001_FFFE, 1'b0), 0);
        // Just below, at and just above the point where the particle expires.
        send_particle(make_particle(18'd65535, 24'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                    32'h0, 32'h1234_5678, 32'h0100_0100, 1'b0), 0);
        send_particle(make_particle(18'd65536, 24'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                    32'h0, 32'h1234_5678, 32'h0100_0100, 1'b1), 0);
        send_particle(make_particle(18'd65537, 24'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                    32'h0, 32'h1234_5678, 32'h0100_0100, 1'b0), 0);
        // Past the end value the blend extrapolates and clips to the channel range.
        send_particle(make_particle(18'd131072, 24'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                    32'h0, 32'h80C0_4020, 32'h8000_4000, 1'b0), 0);
        send_particle(make_particle(18'h3_FFFF, 24'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                    32'h0, 32'h7F7F_7F7F, 32'h7FFF_8000, 1'b1), 0);
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int recv_stall_pct);
        stall_pct = recv_stall_pct;
        repeat (3) begin
            wait_for_drain();
            apply_config(random_cfg());
            repeat (140) send_particle(random_particle(), idle_pct);
        end
        wait_for_drain();
    endtask

    // The output holds off long enough for the pipeline to fill and stall its input.
    task automatic test_backpressure_hold();
        stall_pct = 0;
        wait_for_drain();
        apply_config(random_cfg());
        hold_left <= 64;
        repeat (50) send_particle(random_particle(), 0);
        wait_for_drain();
    endtask

    initial begin
        cfg_now = make_cfg(pev_pkg::TIME_STEP_RST, 32'h0, 32'h0, 32'h0, pev_pkg::DAMPING_RST,
                           32'h0, 32'h0, 2'b00);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_field_extremes();
        test_lerp_boundaries();
        test_random_traffic(0, 0);
        test_random_traffic(47, 0);
        test_random_traffic(0, 47);
        test_random_traffic(29, 29);
        test_backpressure_hold();
        wait_for_drain();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
